// ----- rtl/oahi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_pkg: shared types and constants of the hash insert block
// Field widths, register indexes, result codes and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package oahi_pkg;

  // field widths
  localparam int KEY_W       = 31;
  localparam int TS_W        = 11;
  localparam int SLOT_W      = 10;
  localparam int STAT_W      = 2;
  localparam int OCC_W       = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  // divider bit counter
  localparam int BCNT_W = $clog2(KEY_W);

  // default number of slots in the store
  localparam int DEF_MAX_SLOTS = 1024;

  // register reset values
  localparam logic [TS_W-1:0] TS_RESET = TS_W'(7);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TABLE_SIZE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_PROBE_MODE = CFG_ADDR_W'(1);

  // result codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_t;

  // commands from the controller
  typedef struct packed {
    logic    clr_wr;
    logic    load_key;
    logic    div_step;
    logic    probe_init;
    logic    probe_adv;
    logic    wr_key;
    logic    set_res;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // status back from the datapath
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic hit_empty;
    logic hit_match;
    logic probe_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/oahi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_ctrl: sequencer of the hash insert block
// Runs the clearing pass after reset, then for each item the key division,
// the slot probe loop and the hand-over of the result.
// ----------------------------------------------------------------------------
module oahi_ctrl
  import oahi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_INIT,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_INSERTED;
    in_ready       = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit_empty) begin
          cmd.wr_key     = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_INSERTED;
          state_next     = S_OUT;
        end else if (sts.hit_match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_PRESENT;
          state_next     = S_OUT;
        end else if (sts.probe_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NO_FREE;
          state_next     = S_OUT;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_READ;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/oahi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_datapath: registers, divider, probe unit and slot store
// Holds the configuration, reduces the key modulo the table size one bit
// a cycle, walks the probe sequence and keeps the slot store and count.
// ----------------------------------------------------------------------------
module oahi_datapath
  import oahi_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [KEY_W-1:0]       in_key,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int PW = TS_W + 1;
  localparam int LW = (CW > TS_W) ? CW + 2 : TS_W + 2;

  // configuration
  logic [TS_W-1:0] size_cfg;
  logic            probe_mode;
  logic [TS_W-1:0] eff;

  // divider
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  div_sh;
  logic [BCNT_W-1:0] bcnt;
  logic [PW-1:0]     rem;
  logic [PW-1:0]     rem_sh;
  logic [PW-1:0]     rem_next;

  // probe unit
  logic [AW-1:0]   cur;
  logic [AW-1:0]   home;
  logic [TS_W-1:0] step;
  logic [TS_W-1:0] kcnt;
  logic [PW-1:0]   cur_sum;
  logic [PW-1:0]   cur_next;
  logic [PW-1:0]   step_sum;
  logic [TS_W-1:0] step_next;

  // slot store: used mark above the key
  logic [KEY_W:0]  mem [MAX_SLOTS];
  logic [KEY_W:0]  rdata;
  logic [AW-1:0]   clr_addr;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [KEY_W:0]  wdata;
  logic [CW-1:0]   count;

  // result
  logic [AW-1:0]   res_slot;
  status_t         res_status;
  logic [LW-1:0]   load_lhs;
  logic [LW-1:0]   load_rhs;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg   <= TS_RESET;
      probe_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TABLE_SIZE: size_cfg <= cfg_wdata[TS_W-1:0];
        REG_PROBE_MODE: probe_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // size in use, zero taken as one and clamped to the store depth
  always_comb begin
    eff = size_cfg;
    if (size_cfg == '0) begin
      eff = TS_W'(1);
    end else if (int'(size_cfg) > MAX_SLOTS) begin
      eff = TS_W'(MAX_SLOTS);
    end
  end

  // restoring division, one key bit a cycle
  assign rem_sh   = {rem[PW-2:0], div_sh[KEY_W-1]};
  assign rem_next = (rem_sh >= PW'(eff)) ? rem_sh - PW'(eff) : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r  <= in_key;
      div_sh <= in_key;
      rem    <= '0;
      bcnt   <= BCNT_W'(KEY_W - 1);
    end else if (cmd.div_step) begin
      div_sh <= div_sh << 1;
      rem    <= rem_next;
      bcnt   <= bcnt - BCNT_W'(1);
    end
  end

  // next probe position and quadratic step, both kept below the size
  assign cur_sum  = PW'(cur) + PW'(step);
  assign cur_next = (cur_sum >= PW'(eff)) ? cur_sum - PW'(eff) : cur_sum;
  assign step_sum = PW'(step) + PW'(2);

  always_comb begin
    if (eff == TS_W'(1)) begin
      step_next = '0;
    end else if (step_sum >= PW'(eff)) begin
      step_next = TS_W'(step_sum - PW'(eff));
    end else begin
      step_next = TS_W'(step_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      cur  <= AW'(rem);
      home <= AW'(rem);
      step <= (eff == TS_W'(1)) ? TS_W'(0) : TS_W'(1);
      kcnt <= '0;
    end else if (cmd.probe_adv) begin
      cur  <= AW'(cur_next);
      kcnt <= kcnt + TS_W'(1);
      if (probe_mode) begin
        step <= step_next;
      end
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // slot store, read every cycle at the probe position
  assign mem_we = cmd.clr_wr | cmd.wr_key;
  assign waddr  = cmd.clr_wr ? clr_addr : cur;
  assign wdata  = cmd.clr_wr ? '0 : {1'b1, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cur];
  end

  // occupied slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_key) begin
      count <= count + CW'(1);
    end
  end

  // result capture, home slot when no slot was found
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_slot   <= (cmd.res_status == ST_NO_FREE) ? home : cur;
    end
  end

  // load above three quarters: count * 4 against size * 3
  assign load_lhs = LW'(count) << 2;
  assign load_rhs = LW'(eff) + (LW'(eff) << 1);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {load_lhs > load_rhs, OCC_W'(count), res_status, SLOT_W'(res_slot)};
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_done   = (clr_addr == AW'(MAX_SLOTS - 1));
    sts.div_done   = (bcnt == '0);
    sts.hit_empty  = !rdata[KEY_W];
    sts.hit_match  = (rdata[KEY_W-1:0] == key_r);
    sts.probe_last = (kcnt == eff - TS_W'(1));
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

// ----- rtl/open_addressing_hash_insert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert: open-addressed hash table, insert only
// Inserts each key into the slot store by linear or quadratic probing and
// reports the slot, the outcome, the occupied count and a high-load flag.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot store, one slot a cycle, and accepts
// no item until that is done; configuration writes are taken throughout.
// It then works on one item at a time and probes from one slot up to as
// many as the table has. The key is reduced modulo the table size by a
// bit-serial divider, and each probe is one registered read of the store
// followed by a compare. A finished result waits in the output register
// while the next item is accepted. A key that finds neither a free slot
// nor its match gives status 2 and the home slot after as many probes as
// the table has slots.
module open_addressing_hash_insert
  import oahi_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[30:0], zero[31]
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // slot, status, occupied, load_high
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  oahi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  oahi_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- rtl/oahi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahi_checker: port-level checks of the hash insert block
// Watches the top-level handshakes over time and is bound to the top level.
// ----------------------------------------------------------------------------
module oahi_checker
  import oahi_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // reset starts the clearing pass with nothing shown at the output
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or result shown straight after reset");

  // one item at a time: ready drops once an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready held after an item was taken");

  // the key division alone keeps a result from following an item at once
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared the cycle after an item was taken");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind open_addressing_hash_insert oahi_checker u_oahi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
